// ===== design/thermistor_fan_p_controller_macros.svh =====
// Assertion macros used by the thermistor fan controller checker.
`ifndef THERMISTOR_FAN_P_CONTROLLER_MACROS_SVH
`define THERMISTOR_FAN_P_CONTROLLER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define TFPC_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define TFPC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/tfpc_pkg.sv =====
// Shared widths, constants and segment tables of the thermistor fan controller.
package tfpc_pkg;

    localparam int ADC_BITS = 12;
    localparam int ADC_FS   = (1 << ADC_BITS) - 1;

    localparam int IN_TW   = ((ADC_BITS + 7) / 8) * 8;
    localparam int DUTY_W  = 10;
    localparam int TEMP_W  = 8;
    localparam int OUT_TW  = ((DUTY_W + TEMP_W + 7) / 8) * 8;
    localparam int SP_W    = 8;
    localparam int GAIN_W  = 10;
    localparam int CFG_W   = 10;
    localparam int CFG_AW  = 2;

    // Datapath widths
    localparam int KW      = ADC_BITS + 6;   // 33 * code
    localparam int BW      = 19;             // segment B coefficient
    localparam int CCW     = 12;             // segment C coefficient
    localparam int PW      = ADC_BITS + 24;  // B * K and A * F
    localparam int DW      = ADC_BITS + 17;  // C * K, the divisor
    localparam int NW      = PW + 8;         // dividend magnitude, scaled by 256
    localparam int CW      = NW + 1;         // divider compare width
    localparam int TQ_BITS = 16;             // temperature, 8 fraction bits
    localparam int ERR_W   = 18;
    localparam int UW      = ERR_W + GAIN_W + 1;

    localparam logic signed [TQ_BITS-1:0] TQ_MIN = 16'sh8000;
    localparam logic signed [TQ_BITS-1:0] TQ_MAX = 16'sh7FFF;

    // Configuration register indexes
    localparam logic [CFG_AW-1:0] REG_SETPOINT = 2'd0;
    localparam logic [CFG_AW-1:0] REG_GAIN     = 2'd1;
    localparam logic [CFG_AW-1:0] REG_DUTY_MAX = 2'd2;
    localparam logic [CFG_AW-1:0] REG_DUTY_MIN = 2'd3;

    localparam logic [SP_W-1:0]   SETPOINT_RST = 8'd30;
    localparam logic [GAIN_W-1:0] GAIN_RST     = 10'd300;
    localparam logic [DUTY_W-1:0] DUTY_MAX_RST = 10'd998;
    localparam logic [DUTY_W-1:0] DUTY_MIN_RST = 10'd0;

    // code * 330 < E * FS  <=>  code < ceil(E * FS / 330)
    localparam logic [ADC_BITS-1:0] SEG_TH0 = ADC_BITS'((174 * ADC_FS + 329) / 330);
    localparam logic [ADC_BITS-1:0] SEG_TH1 = ADC_BITS'((222 * ADC_FS + 329) / 330);
    localparam logic [ADC_BITS-1:0] SEG_TH2 = ADC_BITS'((259 * ADC_FS + 329) / 330);
    localparam logic [ADC_BITS-1:0] SEG_TH3 = ADC_BITS'((284 * ADC_FS + 329) / 330);

    localparam int SEG_W = 3;
    localparam logic [SEG_W-1:0] SEG0 = 3'd0;
    localparam logic [SEG_W-1:0] SEG1 = 3'd1;
    localparam logic [SEG_W-1:0] SEG2 = 3'd2;
    localparam logic [SEG_W-1:0] SEG3 = 3'd3;
    localparam logic [SEG_W-1:0] SEG4 = 3'd4;

    // A * F with F = 10 * FS
    localparam logic [PW-1:0] AF_LOW  = PW'(longint'(165000) * 10 * ADC_FS);
    localparam logic [PW-1:0] AF_HIGH = PW'(longint'(330000) * 10 * ADC_FS);

    function automatic logic [BW-1:0] seg_b(input logic [SEG_W-1:0] seg);
        case (seg)
            SEG0:    seg_b = BW'(171225);
            SEG1:    seg_b = BW'(262460);
            SEG2:    seg_b = BW'(205960);
            SEG3:    seg_b = BW'(169120);
            default: seg_b = BW'(145640);
        endcase
    endfunction

    function automatic logic [CCW-1:0] seg_c(input logic [SEG_W-1:0] seg);
        case (seg)
            SEG0:    seg_c = CCW'(2849);
            SEG1:    seg_c = CCW'(2729);
            SEG2:    seg_c = CCW'(1383);
            SEG3:    seg_c = CCW'(737);
            default: seg_c = CCW'(411);
        endcase
    endfunction

    function automatic logic [PW-1:0] seg_af(input logic [SEG_W-1:0] seg);
        case (seg)
            SEG0:    seg_af = AF_LOW;
            default: seg_af = AF_HIGH;
        endcase
    endfunction

endpackage

// ===== design/thermistor_fan_p_controller.sv =====
// Thermistor fan controller: ADC code to temperature and proportional fan duty.
//
// Input channel s_axis: one ADC sample per transfer in tdata. Output channel
// m_axis: one result per input, fan duty compare value and whole temperature.
// Configuration: cfg_we / cfg_addr / cfg_wdata write setpoint (0), gain (1),
// duty upper clamp (2) and duty lower clamp (3); write only while idle.
//
// Throughput: one sample per cycle while the skid register is empty. The depth
// of the pipeline is set by the restoring divider, one quotient bit per stage
// over 16 stages, plus input capture, segment select, the coefficient
// multiply, the signed split of the dividend, the temperature saturation,
// the gain multiply and the output register.
//
// Reset clears all valid bits and loads the register defaults (30, 300, 998,
// 0); the pipeline is empty and s_axis_tready is high after reset.
// When m_axis stalls, the output register holds and a skid register takes
// the next result; s_axis_tready drops only while the skid register is
// full, so nothing is lost or repeated.
module thermistor_fan_p_controller
    import tfpc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [IN_TW-1:0]  s_axis_tdata,   // [11:0] adc_code, rest zero
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [OUT_TW-1:0] m_axis_tdata,   // [9:0] duty_compare, [17:10] temperature_whole
    input  logic              cfg_we,
    input  logic [CFG_AW-1:0] cfg_addr,
    input  logic [CFG_W-1:0]  cfg_wdata
);

    localparam int QB = TQ_BITS;

    // Configuration registers
    logic [SP_W-1:0]   setpoint_reg;
    logic [GAIN_W-1:0] gain_reg;
    logic [DUTY_W-1:0] duty_max_reg;
    logic [DUTY_W-1:0] duty_min_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            setpoint_reg <= SETPOINT_RST;
            gain_reg     <= GAIN_RST;
            duty_max_reg <= DUTY_MAX_RST;
            duty_min_reg <= DUTY_MIN_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_SETPOINT: setpoint_reg <= cfg_wdata[SP_W-1:0];
                REG_GAIN:     gain_reg     <= cfg_wdata[GAIN_W-1:0];
                REG_DUTY_MAX: duty_max_reg <= cfg_wdata[DUTY_W-1:0];
                REG_DUTY_MIN: duty_min_reg <= cfg_wdata[DUTY_W-1:0];
                default: ;
            endcase
        end
    end

    // Pipeline enable: advance whenever the skid register is free
    logic skid_valid_reg;
    logic en;
    assign en            = !skid_valid_reg;
    assign s_axis_tready = en;

    // Stage 1: capture sample
    logic                v1_reg;
    logic [ADC_BITS-1:0] code1_reg;

    // Stage 2: segment select and K = 33 * code
    logic             v2_reg;
    logic [KW-1:0]    k2_reg;
    logic [SEG_W-1:0] seg2_reg;
    logic             zero2_reg;
    logic [KW-1:0]    k2_next;
    logic [SEG_W-1:0] seg2_next;

    always_comb
    begin
        k2_next   = KW'({code1_reg, 5'b00000}) + KW'(code1_reg);
        seg2_next = SEG4;
        if (code1_reg < SEG_TH3)
            seg2_next = SEG3;
        if (code1_reg < SEG_TH2)
            seg2_next = SEG2;
        if (code1_reg < SEG_TH1)
            seg2_next = SEG1;
        if (code1_reg < SEG_TH0)
            seg2_next = SEG0;
    end

    // Stage 3: B * K and C * K
    logic             v3_reg;
    logic [PW-1:0]    p3_reg;
    logic [DW-1:0]    d3_reg;
    logic [SEG_W-1:0] seg3_reg;
    logic             zero3_reg;
    logic [PW-1:0]    p3_next;
    logic [DW-1:0]    d3_next;

    assign p3_next = PW'(seg_b(seg2_reg)) * PW'(k2_reg);
    assign d3_next = DW'(seg_c(seg2_reg)) * DW'(k2_reg);

    // Divider stages; index 0 holds the signed split of the dividend
    logic          dv_reg    [0:QB];
    logic [NW-1:0] drem_reg  [0:QB];
    logic [DW-1:0] dden_reg  [0:QB];
    logic          dneg_reg  [0:QB];
    logic          dzero_reg [0:QB];
    logic [QB-1:0] quo_reg   [1:QB];
    logic [NW-1:0] drem_next [1:QB];
    logic [QB-1:0] quo_next  [1:QB];

    logic signed [PW:0] diff;
    logic [PW-1:0]      mag;
    logic [NW-1:0]      rem0_next;
    logic               neg0_next;

    always_comb
    begin
        diff      = $signed({1'b0, p3_reg}) - $signed({1'b0, seg_af(seg3_reg)});
        neg0_next = diff[PW];
        mag       = neg0_next ? PW'(-diff) : PW'(diff);
        rem0_next = {mag, 8'h00};
    end

    for (genvar i = 0; i < QB; i++)
    begin : g_div
        localparam int SH = QB - 1 - i;
        logic [QB-1:0] q_prev;
        logic [CW-1:0] shifted;
        logic          fits;

        if (i == 0)
        begin : g_first
            assign q_prev = '0;
        end
        else
        begin : g_rest
            assign q_prev = quo_reg[i];
        end

        always_comb
        begin
            shifted       = CW'(dden_reg[i]) << SH;
            fits          = CW'(drem_reg[i]) >= shifted;
            drem_next[i+1] = fits ? NW'(CW'(drem_reg[i]) - shifted) : drem_reg[i];
            quo_next[i+1]  = {q_prev[QB-2:0], fits};
        end
    end

    // Temperature stage: sign, saturation, code zero
    logic                      vt_reg;
    logic signed [TQ_BITS-1:0] t_reg;
    logic signed [TQ_BITS-1:0] t_next;
    logic [TQ_BITS-1:0]        qmag;

    always_comb
    begin
        qmag = {1'b0, quo_reg[QB][QB-2:0]};
        if (dzero_reg[QB])
            t_next = TQ_MIN;
        else if (quo_reg[QB][QB-1])
            t_next = dneg_reg[QB] ? TQ_MIN : TQ_MAX;
        else if (dneg_reg[QB])
            t_next = -$signed(qmag);
        else
            t_next = $signed(qmag);
    end

    // Gain stage: u = gain * (T - setpoint), whole degrees toward zero
    logic                    vu_reg;
    logic signed [UW-1:0]    u_reg;
    logic [TEMP_W-1:0]       whole_reg;
    logic signed [ERR_W-1:0] err;
    logic signed [UW-1:0]    u_next;
    logic [TEMP_W-1:0]       whole_next;

    always_comb
    begin
        err        = ERR_W'(t_reg) - $signed({2'b00, setpoint_reg, 8'h00});
        u_next     = UW'(err) * UW'($signed({1'b0, gain_reg}));
        whole_next = t_reg[15:8] + TEMP_W'(t_reg[15] && (t_reg[7:0] != 8'h00));
    end

    // Duty clamp, feeds the output register
    logic signed [UW-1:0] max_q;
    logic signed [UW-1:0] min_q;
    logic [DUTY_W-1:0]    duty_next;

    always_comb
    begin
        max_q = $signed(UW'({duty_max_reg, 8'h00}));
        min_q = $signed(UW'({duty_min_reg, 8'h00}));
        if (u_reg > max_q)
            duty_next = duty_max_reg;
        else if (u_reg < min_q)
            duty_next = duty_min_reg;
        else
            duty_next = u_reg[DUTY_W+7:8];
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            for (int j = 0; j <= QB; j++)
                dv_reg[j] <= 1'b0;
            vt_reg <= 1'b0;
            vu_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg    <= s_axis_tvalid;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            dv_reg[0] <= v3_reg;
            for (int j = 1; j <= QB; j++)
                dv_reg[j] <= dv_reg[j-1];
            vt_reg <= dv_reg[QB];
            vu_reg <= vt_reg;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            code1_reg    <= s_axis_tdata[ADC_BITS-1:0];
            k2_reg       <= k2_next;
            seg2_reg     <= seg2_next;
            zero2_reg    <= (code1_reg == '0);
            p3_reg       <= p3_next;
            d3_reg       <= d3_next;
            seg3_reg     <= seg2_reg;
            zero3_reg    <= zero2_reg;
            drem_reg[0]  <= rem0_next;
            dden_reg[0]  <= d3_reg;
            dneg_reg[0]  <= neg0_next;
            dzero_reg[0] <= zero3_reg;
            for (int j = 1; j <= QB; j++)
            begin
                drem_reg[j]  <= drem_next[j];
                quo_reg[j]   <= quo_next[j];
                dden_reg[j]  <= dden_reg[j-1];
                dneg_reg[j]  <= dneg_reg[j-1];
                dzero_reg[j] <= dzero_reg[j-1];
            end
            t_reg     <= t_next;
            u_reg     <= u_next;
            whole_reg <= whole_next;
        end
    end

    // Output register and skid register
    logic              out_valid_reg;
    logic [DUTY_W-1:0] out_duty_reg;
    logic [TEMP_W-1:0] out_temp_reg;
    logic [DUTY_W-1:0] skid_duty_reg;
    logic [TEMP_W-1:0] skid_temp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || m_axis_tready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
                out_valid_reg <= vu_reg;
        end
        else if (vu_reg && en)
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || m_axis_tready)
        begin
            if (skid_valid_reg)
            begin
                out_duty_reg <= skid_duty_reg;
                out_temp_reg <= skid_temp_reg;
            end
            else
            begin
                out_duty_reg <= duty_next;
                out_temp_reg <= whole_reg;
            end
        end
        else if (vu_reg && en)
        begin
            skid_duty_reg <= duty_next;
            skid_temp_reg <= whole_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_TW'({out_temp_reg, out_duty_reg});

endmodule

// ===== design/tfpc_checker.sv =====
// Port-level checker for the thermistor fan controller, bound to the top level.
`include "thermistor_fan_p_controller_macros.svh"

module tfpc_checker
    import tfpc_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              s_axis_tready,
    input logic              m_axis_tvalid,
    input logic              m_axis_tready,
    input logic [OUT_TW-1:0] m_axis_tdata,   // [9:0] duty_compare, [17:10] temperature_whole
    input logic              cfg_we,
    input logic [CFG_AW-1:0] cfg_addr,
    input logic [CFG_W-1:0]  cfg_wdata
);

    // Track the clamp registers from the write port
    logic [DUTY_W-1:0] duty_max_reg;
    logic [DUTY_W-1:0] duty_min_reg;
    logic [DUTY_W-1:0] duty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            duty_max_reg <= DUTY_MAX_RST;
            duty_min_reg <= DUTY_MIN_RST;
        end
        else if (cfg_we && cfg_addr == REG_DUTY_MAX)
            duty_max_reg <= cfg_wdata[DUTY_W-1:0];
        else if (cfg_we && cfg_addr == REG_DUTY_MIN)
            duty_min_reg <= cfg_wdata[DUTY_W-1:0];
    end

    assign duty = m_axis_tdata[DUTY_W-1:0];

    `TFPC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped while stalled")
    `TFPC_ASSERT_NEXT(a_out_stable, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata), "result changed while stalled")
    `TFPC_ASSERT_IMPL(a_backpressure, !s_axis_tready, m_axis_tvalid, "input held off with no result pending")
    `TFPC_ASSERT_IMPL(a_duty_window, m_axis_tvalid && (duty_min_reg <= duty_max_reg), (duty >= duty_min_reg) && (duty <= duty_max_reg), "duty outside clamp window")

endmodule

bind thermistor_fan_p_controller tfpc_checker u_tfpc_checker (.*);

// ===== bench/tb_thermistor_fan_p_controller.sv =====
// Self-checking testbench for the thermistor fan proportional controller.
`timescale 1ns / 100ps

module tb_thermistor_fan_p_controller
    import tfpc_pkg::*;
();

    localparam int  RESET_CYCLES = 12;
    localparam int  LATENCY      = 22;
    localparam int  CYCLE_LIMIT  = 500000;
    localparam int  NUM_PHASES   = 8;
    localparam int  PHASE_ITEMS  = 75;
    localparam int  NUM_ROWS     = 18;

    typedef struct packed {
        logic [DUTY_W-1:0] duty;
        logic [TEMP_W-1:0] temp;
    } fan_result_t;

    typedef struct packed {
        logic [ADC_BITS-1:0] code;
        logic                given;
        fan_result_t         res;
    } code_row_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [IN_TW-1:0]  s_data = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [OUT_TW-1:0] m_data;
    logic              cfg_we = 1'b0;
    logic [CFG_AW-1:0] cfg_addr = '0;
    logic [CFG_W-1:0]  cfg_wdata = '0;

    // Register shadow of the block
    logic [SP_W-1:0]   setpoint_sh = SETPOINT_RST;
    logic [GAIN_W-1:0] gain_sh     = GAIN_RST;
    logic [DUTY_W-1:0] duty_max_sh = DUTY_MAX_RST;
    logic [DUTY_W-1:0] duty_min_sh = DUTY_MIN_RST;

    fan_result_t expected_q[$];
    int          mismatches = 0;
    bit          quiet = 1'b0;
    int          cycles = 0;

    // Directed rows at reset settings: extremes, saturation and segment edges
    code_row_t directed_rows [NUM_ROWS] = '{
        '{12'd0,    1'b1, '{10'd0,   8'h80}},
        '{12'd1,    1'b1, '{10'd0,   8'h80}},
        '{12'd4095, 1'b1, '{10'd998, 8'd111}},
        '{12'd2,    1'b0, '{10'd0,   8'd0}},
        '{12'd4094, 1'b0, '{10'd0,   8'd0}},
        '{12'd2159, 1'b0, '{10'd0,   8'd0}},
        '{12'd2160, 1'b0, '{10'd0,   8'd0}},
        '{12'd2754, 1'b0, '{10'd0,   8'd0}},
        '{12'd2755, 1'b0, '{10'd0,   8'd0}},
        '{12'd3213, 1'b0, '{10'd0,   8'd0}},
        '{12'd3214, 1'b0, '{10'd0,   8'd0}},
        '{12'd3524, 1'b0, '{10'd0,   8'd0}},
        '{12'd3525, 1'b0, '{10'd0,   8'd0}},
        '{12'h555,  1'b0, '{10'd0,   8'd0}},
        '{12'hAAA,  1'b0, '{10'd0,   8'd0}},
        '{12'h800,  1'b0, '{10'd0,   8'd0}},
        '{12'h7FF,  1'b0, '{10'd0,   8'd0}},
        '{12'd3900, 1'b0, '{10'd0,   8'd0}}
    };

    thermistor_fan_p_controller u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_ready),
        .s_axis_tdata  (s_data),
        .m_axis_tvalid (m_valid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_data),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    always #6 clk = ~clk;

    // Temperature in 8.8 fixed point, then proportional duty with clamps
    function automatic fan_result_t predict_fan(input logic [ADC_BITS-1:0] code);
        longint      c;
        longint      lim;
        longint      a_co;
        longint      b_co;
        longint      c_co;
        longint      tq;
        longint      u;
        longint      duty;
        longint      whole;
        int          seg;
        fan_result_t r;
        c = longint'(code);
        if (c == 0)
            tq = -32768;
        else
        begin
            seg = 4;
            for (int i = 3; i >= 0; i--)
            begin
                case (i)
                    0:       lim = 174;
                    1:       lim = 222;
                    2:       lim = 259;
                    default: lim = 284;
                endcase
                if (c * 330 < lim * ADC_FS)
                    seg = i;
            end
            case (seg)
                0:       begin a_co = 165000; b_co = 171225; c_co = 2849; end
                1:       begin a_co = 330000; b_co = 262460; c_co = 2729; end
                2:       begin a_co = 330000; b_co = 205960; c_co = 1383; end
                3:       begin a_co = 330000; b_co = 169120; c_co = 737;  end
                default: begin a_co = 330000; b_co = 145640; c_co = 411;  end
            endcase
            tq = ((b_co * 33 * c - a_co * 10 * ADC_FS) * 256) / (c_co * 33 * c);
            if (tq < -32768)
                tq = -32768;
            if (tq > 32767)
                tq = 32767;
        end
        u = longint'(gain_sh) * (tq - longint'(setpoint_sh) * 256);
        if (u > longint'(duty_max_sh) * 256)
            duty = longint'(duty_max_sh);
        else if (u < longint'(duty_min_sh) * 256)
            duty = longint'(duty_min_sh);
        else
            duty = u / 256;
        whole = tq / 256;
        r.duty = duty[DUTY_W-1:0];
        r.temp = whole[TEMP_W-1:0];
        return r;
    endfunction

    // Mostly no gap, some short, a few long
    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    function automatic logic [ADC_BITS-1:0] pick_code();
        int r;
        int base;
        r = $urandom_range(0, 99);
        if (r < 55)
            return ADC_BITS'($urandom_range(0, ADC_FS));
        if (r < 75)
        begin
            case ($urandom_range(0, 3))
                0:       base = 2160;
                1:       base = 2755;
                2:       base = 3214;
                default: base = 3525;
            endcase
            return ADC_BITS'(base + $urandom_range(0, 6) - 3);
        end
        if (r < 90)
            return ADC_BITS'($urandom_range(3000, ADC_FS));
        if (r < 95)
            return ADC_BITS'($urandom_range(0, 8));
        return ADC_BITS'($urandom_range(ADC_FS - 3, ADC_FS));
    endfunction

    // Offer one sample and hold it until the transfer happens
    task automatic send_code(input logic [ADC_BITS-1:0] code, input logic given,
                             input fan_result_t given_res);
        int gap;
        gap = quiet ? 0 : idle_gap();
        if (gap > 0)
        begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_valid <= 1'b1;
        s_data  <= IN_TW'(code);
        @(posedge clk);
        while (!s_ready)
            @(posedge clk);
        expected_q.push_back(given ? given_res : predict_fan(code));
    endtask

    task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        case (idx)
            REG_SETPOINT: setpoint_sh = val[SP_W-1:0];
            REG_GAIN:     gain_sh     = val[GAIN_W-1:0];
            REG_DUTY_MAX: duty_max_sh = val[DUTY_W-1:0];
            REG_DUTY_MIN: duty_min_sh = val[DUTY_W-1:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Result side: check each transfer, stall at random, hold off twice
    initial
    begin : result_sink
        fan_result_t want;
        int          stall_left;
        int          hold_left;
        int          seen;
        stall_left = 0;
        hold_left  = 0;
        seen       = 0;
        forever
        begin
            @(posedge clk);
            if (m_valid && m_ready)
            begin
                seen++;
                if (expected_q.size() == 0)
                begin
                    $error("result with nothing expected: tdata %h", m_data);
                    mismatches++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (m_data[DUTY_W-1:0] !== want.duty)
                    begin
                        $error("duty_compare: expected %0d, got %0d",
                               want.duty, m_data[DUTY_W-1:0]);
                        mismatches++;
                    end
                    if (m_data[DUTY_W+TEMP_W-1:DUTY_W] !== want.temp)
                    begin
                        $error("temperature_whole: expected %0d, got %0d",
                               $signed(want.temp), $signed(m_data[DUTY_W+TEMP_W-1:DUTY_W]));
                        mismatches++;
                    end
                end
                // Long hold-off so the pipeline fills and input backs up
                if (seen == 150 || seen == 450)
                    hold_left = 400;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                m_ready <= 1'b0;
            end
            else
            begin
                m_ready <= 1'b1;
                if ((seen % 200) < 150)
                    stall_left = idle_gap();
            end
        end
    end

    initial
    begin : watchdog
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin : stimulus
        logic [SP_W-1:0]   sp;
        logic [GAIN_W-1:0] gain;
        logic [DUTY_W-1:0] dmax;
        logic [DUTY_W-1:0] dmin;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NUM_ROWS; i++)
            send_code(directed_rows[i].code, directed_rows[i].given, directed_rows[i].res);
        drain();

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            case (ph)
                0: begin sp = 8'd0;   gain = 10'd1023; dmax = 10'd1023; dmin = 10'd0; end
                1: begin sp = 8'd255; gain = 10'd1;    dmax = 10'd0;    dmin = 10'd0; end
                2:
                begin
                    // crossed clamps
                    sp   = SP_W'($urandom_range(0, 80));
                    gain = GAIN_W'($urandom_range(1, 1023));
                    dmax = DUTY_W'($urandom_range(0, 400));
                    dmin = DUTY_W'($urandom_range(600, 1023));
                end
                3:
                begin
                    sp   = SP_W'($urandom_range(0, 255));
                    gain = '0;
                    dmax = DUTY_W'($urandom_range(0, 1023));
                    dmin = DUTY_W'($urandom_range(0, 1023));
                end
                4:
                begin
                    // low gain widens the unclamped band
                    sp   = SP_W'($urandom_range(0, 60));
                    gain = GAIN_W'($urandom_range(1, 8));
                    dmax = 10'd1023;
                    dmin = 10'd0;
                end
                default:
                begin
                    sp   = SP_W'($urandom_range(0, 255));
                    gain = GAIN_W'($urandom_range(0, 1023));
                    dmax = DUTY_W'($urandom_range(0, 1023));
                    dmin = DUTY_W'($urandom_range(0, 1023));
                end
            endcase
            quiet = (ph == 4 || ph == 6);
            // upper write-data bits are don't-care for the setpoint
            write_reg(REG_SETPOINT, {CFG_W'($urandom_range(0, 3)) << SP_W} | CFG_W'(sp));
            write_reg(REG_GAIN, gain);
            write_reg(REG_DUTY_MAX, dmax);
            write_reg(REG_DUTY_MIN, dmin);
            cfg_we <= 1'b0;
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_code(pick_code(), 1'b0, '0);
            drain();
        end

        repeat (LATENCY + 8) @(posedge clk);
        if (mismatches == 0 && expected_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
